/* design/nlerp_pkg.sv */
package nlerp_pkg;

    localparam int FRAC_BITS = 15;
    localparam int QUO_BITS = FRAC_BITS + 1;
    localparam logic [15:0] FRAC_ONE = 16'd32768;
    localparam logic [15:0] FRAC_ZERO = 16'd0;
    localparam int MAG_W = 31;
    localparam int SQ_W = 2 * MAG_W;
    localparam int SUM_W = 64;

    // four components, index 0 = w, 1 = x, 2 = y, 3 = z
    typedef logic [3:0][15:0] quat_t;

    typedef struct packed {
        logic [15:0] frac;
        logic [SUM_W-1:0] sum;
        logic [3:0] neg;
        logic [3:0][SQ_W-1:0] sq;
    } energy_t;

endpackage

/* design/keyframe_quaternion_nlerp_core.sv */
// keyframe quaternion nlerp core
// input channel (in_valid/in_ready): a query time, two keyframe times and two
// Q2.14 quaternions; output channel (out_valid/out_ready): the Q1.15 blend
// fraction, the unit-length blended quaternion and a degenerate flag.
// one result leaves for every request taken, in order.
// a request passes through the fraction divider (one quotient bit per stage),
// the blend multipliers and the squared-length sum, the normalizer (one result
// bit per stage per component) and the output register.
// throughput is one request per cycle while the receiver does not stall.
// when the receiver stalls with a result held, the whole pipeline freezes and
// in_ready drops in the same cycle; nothing is lost or repeated.
// reset clears every stage valid bit; the block takes requests right after.
module keyframe_quaternion_nlerp_core #(
    parameter int TIME_BITS = 24,
    parameter int COMPONENT_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [TIME_BITS-1:0] query_time,
    input  logic [TIME_BITS-1:0] first_time,
    input  logic [TIME_BITS-1:0] second_time,
    input  logic [15:0] first_w,
    input  logic [15:0] first_x,
    input  logic [15:0] first_y,
    input  logic [15:0] first_z,
    input  logic [15:0] second_w,
    input  logic [15:0] second_x,
    input  logic [15:0] second_y,
    input  logic [15:0] second_z,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] fraction,
    output logic [15:0] out_w,
    output logic [15:0] out_x,
    output logic [15:0] out_y,
    output logic [15:0] out_z,
    output logic degenerate
);
    logic en;
    nlerp_pkg::quat_t first_q, second_q, fq_d, sq_d, res_q;
    logic fr_valid, bl_valid, nm_valid, nm_dg;
    logic [15:0] fr_frac, nm_frac;
    nlerp_pkg::energy_t energy;

    logic out_valid_reg;
    logic [15:0] frac_reg;
    nlerp_pkg::quat_t res_reg;
    logic dg_reg;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign first_q = {first_z, first_y, first_x, first_w};
    assign second_q = {second_z, second_y, second_x, second_w};

    nlerp_frac #(.TIME_BITS(TIME_BITS)) u_frac (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .query_time(query_time), .first_time(first_time), .second_time(second_time),
        .first_q(first_q), .second_q(second_q),
        .valid(fr_valid), .frac(fr_frac), .first_o(fq_d), .second_o(sq_d)
    );

    nlerp_blend u_blend (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fr_valid),
        .frac(fr_frac), .first_q(fq_d), .second_q(sq_d),
        .valid(bl_valid), .energy(energy)
    );

    nlerp_norm #(.COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)) u_norm (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(bl_valid), .energy(energy),
        .valid(nm_valid), .frac(nm_frac), .degenerate(nm_dg), .result(res_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= nm_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_reg <= nm_frac;
            res_reg <= res_q;
            dg_reg <= nm_dg;
        end
    end

    assign out_valid = out_valid_reg;
    assign fraction = frac_reg;
    assign out_w = res_reg[0];
    assign out_x = res_reg[1];
    assign out_y = res_reg[2];
    assign out_z = res_reg[3];
    assign degenerate = dg_reg;

endmodule

/* design/nlerp_frac.sv */
module nlerp_frac #(
    parameter int TIME_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [TIME_BITS-1:0] query_time,
    input  logic [TIME_BITS-1:0] first_time,
    input  logic [TIME_BITS-1:0] second_time,
    input  nlerp_pkg::quat_t first_q,
    input  nlerp_pkg::quat_t second_q,
    output logic valid,
    output logic [15:0] frac,
    output nlerp_pkg::quat_t first_o,
    output nlerp_pkg::quat_t second_o
);
    localparam int STEPS = nlerp_pkg::QUO_BITS;

    logic signed [TIME_BITS:0] n_s;
    logic signed [TIME_BITS:0] d_s;
    logic signed [TIME_BITS:0] nn;
    logic signed [TIME_BITS:0] dd;
    logic [TIME_BITS+14:0] dividend;
    logic special_next;
    logic [15:0] fsp_next;

    logic v_reg [0:STEPS];
    logic sp_reg [0:STEPS];
    logic [15:0] fsp_reg [0:STEPS];
    logic [TIME_BITS-1:0] rem_reg [0:STEPS];
    logic [15:0] low_reg [0:STEPS];
    logic [15:0] q_reg [0:STEPS];
    logic [TIME_BITS-1:0] den_reg [0:STEPS];
    nlerp_pkg::quat_t fq_reg [0:STEPS];
    nlerp_pkg::quat_t sq_reg [0:STEPS];

    always_comb
    begin
        n_s = $signed({1'b0, query_time}) - $signed({1'b0, first_time});
        d_s = $signed({1'b0, second_time}) - $signed({1'b0, first_time});
        if (d_s < 0)
        begin
            nn = -n_s;
            dd = -d_s;
        end
        else
        begin
            nn = n_s;
            dd = d_s;
        end
        special_next = (dd == 0) || (nn <= 0) || (nn >= dd);
        if (dd == 0)
            fsp_next = (query_time > first_time) ? nlerp_pkg::FRAC_ONE : nlerp_pkg::FRAC_ZERO;
        else if (nn <= 0)
            fsp_next = nlerp_pkg::FRAC_ZERO;
        else
            fsp_next = nlerp_pkg::FRAC_ONE;
        // n * 2^15 + d / 2, rounding half up after the divide
        dividend = {nn[TIME_BITS-1:0], 15'd0}
                 + (TIME_BITS+15)'(dd[TIME_BITS-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg[0] <= special_next;
            fsp_reg[0] <= fsp_next;
            rem_reg[0] <= TIME_BITS'(dividend >> 16);
            low_reg[0] <= dividend[15:0];
            q_reg[0] <= '0;
            den_reg[0] <= dd[TIME_BITS-1:0];
            fq_reg[0] <= first_q;
            sq_reg[0] <= second_q;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [TIME_BITS:0] shifted;
        logic ge;
        logic [TIME_BITS-1:0] rem_next;

        always_comb
        begin
            shifted = {rem_reg[k], low_reg[k][15]};
            ge = shifted >= {1'b0, den_reg[k]};
            rem_next = ge ? TIME_BITS'(shifted - {1'b0, den_reg[k]})
                          : TIME_BITS'(shifted);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sp_reg[k+1] <= sp_reg[k];
                fsp_reg[k+1] <= fsp_reg[k];
                rem_reg[k+1] <= rem_next;
                low_reg[k+1] <= {low_reg[k][14:0], 1'b0};
                q_reg[k+1] <= {q_reg[k][14:0], ge};
                den_reg[k+1] <= den_reg[k];
                fq_reg[k+1] <= fq_reg[k];
                sq_reg[k+1] <= sq_reg[k];
            end
        end
    end

    assign valid = v_reg[STEPS];
    assign frac = sp_reg[STEPS] ? fsp_reg[STEPS] : q_reg[STEPS];
    assign first_o = fq_reg[STEPS];
    assign second_o = sq_reg[STEPS];

endmodule

/* design/nlerp_blend.sv */
module nlerp_blend (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [15:0] frac,
    input  nlerp_pkg::quat_t first_q,
    input  nlerp_pkg::quat_t second_q,
    output logic valid,
    output nlerp_pkg::energy_t energy
);
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0] frac1_reg, frac2_reg, frac3_reg;
    logic signed [15:0] p1_reg [4];
    logic signed [16:0] diff1_reg [4];
    logic signed [33:0] r2_reg [4];
    logic [nlerp_pkg::SQ_W-1:0] sq3_reg [4];
    logic [3:0] neg3_reg;
    nlerp_pkg::energy_t energy_reg;

    logic signed [33:0] r_next [4];
    logic [nlerp_pkg::MAG_W-1:0] mag_next [4];
    logic [nlerp_pkg::SQ_W-1:0] sq_next [4];
    nlerp_pkg::energy_t energy_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            r_next[i] = (34'(p1_reg[i]) <<< 15)
                      + $signed({1'b0, frac1_reg}) * diff1_reg[i];
            mag_next[i] = r2_reg[i][33] ? nlerp_pkg::MAG_W'(-r2_reg[i])
                                         : nlerp_pkg::MAG_W'(r2_reg[i]);
            sq_next[i] = mag_next[i] * mag_next[i];
        end
        energy_next.frac = frac3_reg;
        energy_next.neg = neg3_reg;
        energy_next.sum = nlerp_pkg::SUM_W'(sq3_reg[0]) + nlerp_pkg::SUM_W'(sq3_reg[1])
                        + nlerp_pkg::SUM_W'(sq3_reg[2]) + nlerp_pkg::SUM_W'(sq3_reg[3]);
        for (int i = 0; i < 4; i++)
            energy_next.sq[i] = sq3_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac1_reg <= frac;
            frac2_reg <= frac1_reg;
            frac3_reg <= frac2_reg;
            for (int i = 0; i < 4; i++)
            begin
                p1_reg[i] <= $signed(first_q[i]);
                diff1_reg[i] <= 17'($signed(second_q[i])) - 17'($signed(first_q[i]));
                r2_reg[i] <= r_next[i];
                sq3_reg[i] <= sq_next[i];
                neg3_reg[i] <= r2_reg[i][33];
            end
            energy_reg <= energy_next;
        end
    end

    assign valid = v4_reg;
    assign energy = energy_reg;

endmodule

/* design/nlerp_norm.sv */
module nlerp_norm #(
    parameter int COMPONENT_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  nlerp_pkg::energy_t energy,
    output logic valid,
    output logic [15:0] frac,
    output logic degenerate,
    output nlerp_pkg::quat_t result
);
    localparam int F = COMPONENT_FRAC_BITS;
    localparam int STEPS = F + 1;
    localparam int SW = 2 * F + 70;

    logic v_reg [0:STEPS];
    logic [15:0] frac_reg [0:STEPS];
    logic dg_reg [0:STEPS];
    logic [3:0] neg_reg [0:STEPS];
    logic signed [SW-1:0] s_reg [0:STEPS];
    logic signed [SW-1:0] x2_reg [0:STEPS][4];
    logic signed [SW-1:0] p_reg [0:STEPS][4];
    logic signed [SW-1:0] q_reg [0:STEPS][4];
    logic [F:0] m_reg [0:STEPS][4];

    logic signed [SW-1:0] s_next;

    assign s_next = SW'(energy.sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    // start from m = 0, i.e. u = 2m - 1 = -1: P = u*u*s, Q = u*s
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_reg[0] <= energy.frac;
            dg_reg[0] <= (energy.sum == '0);
            neg_reg[0] <= energy.neg;
            s_reg[0] <= s_next;
            for (int i = 0; i < 4; i++)
            begin
                x2_reg[0][i] <= SW'(energy.sq[i]) <<< (2 * F + 2);
                p_reg[0][i] <= s_next;
                q_reg[0][i] <= -s_next;
                m_reg[0][i] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int J = F - k;
        logic signed [SW-1:0] pc [4];
        logic ok [4];
        logic signed [SW-1:0] p_next [4];
        logic signed [SW-1:0] q_next [4];
        logic [F:0] m_next [4];

        // setting bit J of m grows u by 2^(J+1)
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                pc[i] = p_reg[k][i] + (q_reg[k][i] <<< (J + 2))
                      + (s_reg[k] <<< (2 * J + 2));
                ok[i] = pc[i] <= x2_reg[k][i];
                p_next[i] = ok[i] ? pc[i] : p_reg[k][i];
                q_next[i] = ok[i] ? q_reg[k][i] + (s_reg[k] <<< (J + 1)) : q_reg[k][i];
                m_next[i] = m_reg[k][i];
                if (ok[i])
                    m_next[i][J] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                frac_reg[k+1] <= frac_reg[k];
                dg_reg[k+1] <= dg_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                s_reg[k+1] <= s_reg[k];
                for (int i = 0; i < 4; i++)
                begin
                    x2_reg[k+1][i] <= x2_reg[k][i];
                    p_reg[k+1][i] <= p_next[i];
                    q_reg[k+1][i] <= q_next[i];
                    m_reg[k+1][i] <= m_next[i];
                end
            end
        end
    end

    logic signed [F+1:0] sv [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sv[i] = neg_reg[STEPS][i] ? -$signed({1'b0, m_reg[STEPS][i]})
                                      : $signed({1'b0, m_reg[STEPS][i]});
            result[i] = dg_reg[STEPS] ? 16'd0 : 16'(sv[i]);
        end
    end

    assign valid = v_reg[STEPS];
    assign frac = frac_reg[STEPS];
    assign degenerate = dg_reg[STEPS];

endmodule

/* design/nlerp_checker.sv */
module nlerp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] fraction,
    input logic [15:0] out_w,
    input logic [15:0] out_x,
    input logic [15:0] out_y,
    input logic [15:0] out_z,
    input logic degenerate
);
    // a held result stays put (checked on out_valid, fraction and out_w)
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fraction) && $stable(out_w))
        else $error("result changed while stalled");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fraction <= 16'd32768)
        else $error("fraction above one");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> out_w == 16'd0 && out_x == 16'd0
            && out_y == 16'd0 && out_z == 16'd0)
        else $error("degenerate result not zero");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

endmodule

bind keyframe_quaternion_nlerp_core nlerp_checker u_nlerp_checker (.*);
